@@ rtl/aavr_pkg.sv @@
package aavr_pkg;

    // 2^48 / (2 pi), split into two narrow multiplier operands
    localparam logic [23:0] INV2PI_LO   = 24'hDB9391;
    localparam logic [21:0] INV2PI_HI   = 22'h28BE60;
    // pi / 2 in Q32
    localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    // largest folded angle, pi / 4 in Q1.30
    localparam logic [29:0] TH_MAX      = 30'h3243_F6A8;

    // horner divisors of the sine and cosine series
    localparam int          HORNER_STEPS = 5;
    localparam logic [6:0]  SIN_DIV [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0]  COS_DIV [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

    localparam logic signed [67:0] Q16_MAX = 68'sd2147483647;
    localparam logic signed [67:0] Q16_MIN = -68'sd2147483648;

    // vector, angle and zero flag while the axis is normalized
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] ang;
        logic               zero;
    } t_front;

    // axis signs and magnitudes
    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } t_axc;

    // vector, unit axis and zero flag while the matrix is built
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               zero;
    } t_back;

    // drop 30 fraction bits, round half away from zero
    function automatic logic signed [67:0] rnd_q30(input logic signed [67:0] p);
        logic [67:0] mag;
        logic [67:0] rm;
        mag = p[67] ? 68'(-p) : 68'(p);
        rm  = (mag + (68'd1 << 29)) >> 30;
        return p[67] ? -$signed(rm) : $signed(rm);
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat_q16(input logic signed [67:0] r);
        logic signed [31:0] res;
        if (r > Q16_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (r < Q16_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = r[31:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/axis_angle_vector_rotate.sv @@
// rodrigues rotation of a q16.16 vector about an arbitrary axis
// throughput: one item per clock cycle, busy is always low
// the 32-step square root and the 31-step axis divider pipelines make up most of the
//   pipeline depth
// reset: synchronous active-low, clears only the stage valid bits
module axis_angle_vector_rotate
    import aavr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_angle_rad,
    input  logic signed [31:0] i_axis_x,
    input  logic signed [31:0] i_axis_y,
    input  logic signed [31:0] i_axis_z,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_zero_axis
);

    // stage positions in the valid line
    localparam int ST_B6  = 5;
    localparam int SQ_N   = 32;
    localparam int ST_D0  = ST_B6 + SQ_N + 1;
    localparam int DV_N   = 31;
    localparam int ST_DVL = ST_D0 + DV_N;
    localparam int ST_A1  = ST_DVL + 1;
    localparam int ST_A3  = ST_A1 + 2;
    localparam int ST_A4  = ST_A1 + 3;
    localparam int ST_F1  = ST_A4 + 3 * HORNER_STEPS + 1;
    localparam int ST_F2  = ST_F1 + 1;
    localparam int LAT    = ST_F2 + 7;

    // product slots of the matrix stages
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_XS = 6;
    localparam int P_YS = 7;
    localparam int P_ZS = 8;

    logic [LAT-1:0] r_vld;

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[LAT-1];

    // ---------------------------------------------------------------
    // axis magnitudes and normalizing shift
    // ---------------------------------------------------------------
    logic signed [31:0] ax_port [3];
    logic [31:0]        b1_abs  [3];

    always_comb begin
        ax_port[0] = i_axis_x;
        ax_port[1] = i_axis_y;
        ax_port[2] = i_axis_z;
        for (int i = 0; i < 3; i++) begin
            b1_abs[i] = ax_port[i][31] ? 32'(-ax_port[i]) : 32'(ax_port[i]);
        end
    end

    t_front      r_b1_fr, r_b2_fr, r_b3_fr, r_b4_fr, r_b5_fr, r_b6_fr;
    t_axc        r_b1_ax, r_b2_ax, r_b3_ax, r_b4_ax, r_b5_ax, r_b6_ax;
    logic [31:0] r_b2_mx;
    logic [4:0]  r_b3_sh;
    logic [63:0] r_b5_sq [3];
    logic [63:0] r_b6_sum;
    logic [31:0] b2_mx;
    logic [4:0]  b3_msb;
    logic [4:0]  b3_sh;

    // largest magnitude
    always_comb begin
        b2_mx = r_b1_ax.mag[0];
        if (r_b1_ax.mag[1] > b2_mx) begin
            b2_mx = r_b1_ax.mag[1];
        end
        if (r_b1_ax.mag[2] > b2_mx) begin
            b2_mx = r_b1_ax.mag[2];
        end
    end

    // shift that brings the largest magnitude up to bit 30
    always_comb begin
        b3_msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_b2_mx[i]) begin
                b3_msb = 5'(i);
            end
        end
        b3_sh = (b3_msb < 5'd30) ? 5'(5'd30 - b3_msb) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_b1_fr.vx   <= i_vec_x;
        r_b1_fr.vy   <= i_vec_y;
        r_b1_fr.vz   <= i_vec_z;
        r_b1_fr.ang  <= i_angle_rad;
        r_b1_fr.zero <= (i_axis_x == '0) && (i_axis_y == '0) && (i_axis_z == '0);
        for (int i = 0; i < 3; i++) begin
            r_b1_ax.neg[i] <= ax_port[i][31];
            r_b1_ax.mag[i] <= b1_abs[i];
        end
        r_b2_fr <= r_b1_fr;
        r_b2_ax <= r_b1_ax;
        r_b2_mx <= b2_mx;
        r_b3_fr <= r_b2_fr;
        r_b3_ax <= r_b2_ax;
        r_b3_sh <= b3_sh;
        r_b4_fr <= r_b3_fr;
        r_b4_ax.neg <= r_b3_ax.neg;
        for (int i = 0; i < 3; i++) begin
            r_b4_ax.mag[i] <= r_b3_ax.mag[i] << r_b3_sh;
        end
        r_b5_fr <= r_b4_fr;
        r_b5_ax <= r_b4_ax;
        for (int i = 0; i < 3; i++) begin
            r_b5_sq[i] <= 64'(r_b4_ax.mag[i]) * 64'(r_b4_ax.mag[i]);
        end
        r_b6_fr  <= r_b5_fr;
        r_b6_ax  <= r_b5_ax;
        r_b6_sum <= r_b5_sq[0] + r_b5_sq[1] + r_b5_sq[2];
    end

    // ---------------------------------------------------------------
    // square root, one result bit per stage
    // ---------------------------------------------------------------
    logic [63:0] r_sq_n  [SQ_N];
    logic [63:0] r_sq_r  [SQ_N];
    t_front      r_sq_fr [SQ_N];
    t_axc        r_sq_ax [SQ_N];

    for (genvar g = 0; g < SQ_N; g++) begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] n_in;
        logic [63:0] r_in;
        logic [63:0] trial;
        t_front      fr_in;
        t_axc        axc_in;

        if (g == 0) begin : g_first
            assign n_in   = r_b6_sum;
            assign r_in   = '0;
            assign fr_in  = r_b6_fr;
            assign axc_in = r_b6_ax;
        end else begin : g_next
            assign n_in   = r_sq_n[g-1];
            assign r_in   = r_sq_r[g-1];
            assign fr_in  = r_sq_fr[g-1];
            assign axc_in = r_sq_ax[g-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (n_in >= trial) begin
                r_sq_n[g] <= n_in - trial;
                r_sq_r[g] <= (r_in >> 1) + BIT;
            end else begin
                r_sq_n[g] <= n_in;
                r_sq_r[g] <= r_in >> 1;
            end
            r_sq_fr[g] <= fr_in;
            r_sq_ax[g] <= axc_in;
        end
    end

    // ---------------------------------------------------------------
    // unit axis: rounded restoring division, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [62:0] r_d0_rem [3];
    logic [31:0] r_d0_norm;
    logic [2:0]  r_d0_neg;
    t_front      r_d0_fr;
    logic [31:0] d0_norm;

    assign d0_norm = r_sq_r[SQ_N-1][31:0];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d0_rem[i] <= (63'(r_sq_ax[SQ_N-1].mag[i]) << 30) + 63'(d0_norm >> 1);
        end
        r_d0_norm <= d0_norm;
        r_d0_neg  <= r_sq_ax[SQ_N-1].neg;
        r_d0_fr   <= r_sq_fr[SQ_N-1];
    end

    logic [62:0] r_dv_rem  [DV_N][3];
    logic [30:0] r_dv_q    [DV_N][3];
    logic [31:0] r_dv_norm [DV_N];
    logic [2:0]  r_dv_neg  [DV_N];
    t_front      r_dv_fr   [DV_N];

    for (genvar g = 0; g < DV_N; g++) begin : g_dv
        localparam int K = DV_N - 1 - g;
        logic [62:0] rem_in [3];
        logic [30:0] q_in   [3];
        logic [31:0] norm_in;
        logic [2:0]  neg_in;
        t_front      fr_in;
        logic [62:0] dvs;

        if (g == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = r_d0_rem[i];
                    q_in[i]   = '0;
                end
            end
            assign norm_in = r_d0_norm;
            assign neg_in  = r_d0_neg;
            assign fr_in   = r_d0_fr;
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = r_dv_rem[g-1][i];
                    q_in[i]   = r_dv_q[g-1][i];
                end
            end
            assign norm_in = r_dv_norm[g-1];
            assign neg_in  = r_dv_neg[g-1];
            assign fr_in   = r_dv_fr[g-1];
        end

        assign dvs = 63'(norm_in) << K;

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= dvs) begin
                    r_dv_rem[g][i] <= rem_in[i] - dvs;
                    r_dv_q[g][i]   <= q_in[i] | (31'd1 << K);
                end else begin
                    r_dv_rem[g][i] <= rem_in[i];
                    r_dv_q[g][i]   <= q_in[i];
                end
            end
            r_dv_norm[g] <= norm_in;
            r_dv_neg[g]  <= neg_in;
            r_dv_fr[g]   <= fr_in;
        end
    end

    // ---------------------------------------------------------------
    // angle to phase, octant fold, theta and theta squared
    // ---------------------------------------------------------------
    logic signed [31:0] a1_n [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a1_n[i] = r_dv_neg[DV_N-1][i] ? -$signed({1'b0, r_dv_q[DV_N-1][i]})
                                          :  $signed({1'b0, r_dv_q[DV_N-1][i]});
        end
    end

    t_back              r_a1_bk, r_a2_bk, r_a3_bk, r_a4_bk;
    logic signed [56:0] r_a1_plo;
    logic signed [54:0] r_a1_phi;
    logic [31:0]        r_a2_ph;
    logic [2:0]         r_a3_oct, r_a4_oct;
    logic [29:0]        r_a3_th, r_a4_th, r_a4_t;
    logic [63:0]        a2_sum;
    logic [29:0]        a3_q;
    logic [62:0]        a3_prod;
    logic [60:0]        a4_sq;

    always_comb begin
        a2_sum  = (64'(r_a1_phi) << 24) + 64'(r_a1_plo);
        a3_q    = r_a2_ph[29] ? 30'(30'h2000_0000 - 30'(r_a2_ph[28:0])) : 30'(r_a2_ph[28:0]);
        a3_prod = 63'(a3_q) * 63'(HALF_PI_Q32);
        a4_sq   = 61'(r_a3_th) * 61'(r_a3_th) + (61'd1 << 29);
    end

    always_ff @(posedge i_clk) begin
        r_a1_bk.vx   <= r_dv_fr[DV_N-1].vx;
        r_a1_bk.vy   <= r_dv_fr[DV_N-1].vy;
        r_a1_bk.vz   <= r_dv_fr[DV_N-1].vz;
        r_a1_bk.zero <= r_dv_fr[DV_N-1].zero;
        r_a1_bk.nx   <= a1_n[0];
        r_a1_bk.ny   <= a1_n[1];
        r_a1_bk.nz   <= a1_n[2];
        r_a1_plo     <= 57'(r_dv_fr[DV_N-1].ang) * 57'($signed({1'b0, INV2PI_LO}));
        r_a1_phi     <= 55'(r_dv_fr[DV_N-1].ang) * 55'($signed({1'b0, INV2PI_HI}));
        r_a2_bk      <= r_a1_bk;
        r_a2_ph      <= a2_sum[63:32];
        r_a3_bk      <= r_a2_bk;
        r_a3_oct     <= r_a2_ph[31:29];
        r_a3_th      <= a3_prod[61:32];
        r_a4_bk      <= r_a3_bk;
        r_a4_oct     <= r_a3_oct;
        r_a4_th      <= r_a3_th;
        r_a4_t       <= a4_sq[59:30];
    end

    // ---------------------------------------------------------------
    // horner series, lane 0 sine and lane 1 cosine, three stages a step
    // ---------------------------------------------------------------
    t_back       r_hx_bk  [HORNER_STEPS];
    logic [2:0]  r_hx_oct [HORNER_STEPS];
    logic [29:0] r_hx_th  [HORNER_STEPS];
    logic [29:0] r_hx_t   [HORNER_STEPS];
    logic [60:0] r_hx_p   [HORNER_STEPS][2];
    t_back       r_hy_bk  [HORNER_STEPS];
    logic [2:0]  r_hy_oct [HORNER_STEPS];
    logic [29:0] r_hy_th  [HORNER_STEPS];
    logic [29:0] r_hy_t   [HORNER_STEPS];
    logic [29:0] r_hy_x   [HORNER_STEPS][2];
    logic [61:0] r_hy_m   [HORNER_STEPS][2];
    t_back       r_hz_bk  [HORNER_STEPS];
    logic [2:0]  r_hz_oct [HORNER_STEPS];
    logic [29:0] r_hz_th  [HORNER_STEPS];
    logic [29:0] r_hz_t   [HORNER_STEPS];
    logic [30:0] r_hz_h   [HORNER_STEPS][2];

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_hn
        localparam logic [6:0]  DV  [2] = '{SIN_DIV[g], COS_DIV[g]};
        localparam logic [31:0] RCP [2] = '{32'((64'd1 << 32) / 64'(SIN_DIV[g])),
                                            32'((64'd1 << 32) / 64'(COS_DIV[g]))};
        t_back       bk_in;
        logic [2:0]  oct_in;
        logic [29:0] th_in;
        logic [29:0] t_in;
        logic [30:0] h_in [2];
        logic [59:0] x_sum [2];
        logic [29:0] q0 [2];
        logic [29:0] rs [2];

        if (g == 0) begin : g_first
            assign bk_in  = r_a4_bk;
            assign oct_in = r_a4_oct;
            assign th_in  = r_a4_th;
            assign t_in   = r_a4_t;
            assign h_in[0] = ONE_Q30;
            assign h_in[1] = ONE_Q30;
        end else begin : g_next
            assign bk_in  = r_hz_bk[g-1];
            assign oct_in = r_hz_oct[g-1];
            assign th_in  = r_hz_th[g-1];
            assign t_in   = r_hz_t[g-1];
            assign h_in[0] = r_hz_h[g-1][0];
            assign h_in[1] = r_hz_h[g-1][1];
        end

        // rounded product, reciprocal estimate, one-step correction
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                x_sum[l] = 60'(r_hx_p[g][l] + (61'd1 << 29));
                q0[l]    = r_hy_m[g][l][61:32];
                rs[l]    = 30'(r_hy_x[g][l] - 30'(37'(q0[l]) * 37'(DV[l])));
            end
        end

        always_ff @(posedge i_clk) begin
            r_hx_bk[g]  <= bk_in;
            r_hx_oct[g] <= oct_in;
            r_hx_th[g]  <= th_in;
            r_hx_t[g]   <= t_in;
            r_hy_bk[g]  <= r_hx_bk[g];
            r_hy_oct[g] <= r_hx_oct[g];
            r_hy_th[g]  <= r_hx_th[g];
            r_hy_t[g]   <= r_hx_t[g];
            r_hz_bk[g]  <= r_hy_bk[g];
            r_hz_oct[g] <= r_hy_oct[g];
            r_hz_th[g]  <= r_hy_th[g];
            r_hz_t[g]   <= r_hy_t[g];
            for (int l = 0; l < 2; l++) begin
                r_hx_p[g][l] <= 61'(t_in) * 61'(h_in[l]);
                r_hy_x[g][l] <= x_sum[l][59:30];
                r_hy_m[g][l] <= 62'(x_sum[l][59:30]) * 62'(RCP[l]);
                if (rs[l] >= 30'(DV[l])) begin
                    r_hz_h[g][l] <= ONE_Q30 - 31'(q0[l] + 30'd1);
                end else begin
                    r_hz_h[g][l] <= ONE_Q30 - 31'(q0[l]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sine times theta, octant mapping
    // ---------------------------------------------------------------
    localparam int HL = HORNER_STEPS - 1;

    t_back              r_f1_bk, r_f2_bk;
    logic [2:0]         r_f1_oct;
    logic [60:0]        r_f1_ps;
    logic [30:0]        r_f1_hc;
    logic signed [31:0] r_f2_s, r_f2_c;
    logic [60:0]        f2_rs;
    logic signed [31:0] f2_s0, f2_c0, f2_sm, f2_cm;

    always_comb begin
        f2_rs = r_f1_ps + (61'd1 << 29);
        f2_s0 = $signed({1'b0, f2_rs[60:30]});
        f2_c0 = $signed({1'b0, r_f1_hc});
        f2_sm = (r_f1_oct[0] ^ r_f1_oct[1]) ? f2_c0 : f2_s0;
        f2_cm = (r_f1_oct[0] ^ r_f1_oct[1]) ? f2_s0 : f2_c0;
    end

    always_ff @(posedge i_clk) begin
        r_f1_bk  <= r_hz_bk[HL];
        r_f1_oct <= r_hz_oct[HL];
        r_f1_ps  <= 61'(r_hz_th[HL]) * 61'(r_hz_h[HL][0]);
        r_f1_hc  <= r_hz_h[HL][1];
        r_f2_bk  <= r_f1_bk;
        r_f2_s   <= r_f1_oct[2] ? -f2_sm : f2_sm;
        r_f2_c   <= (r_f1_oct[1] ^ r_f1_oct[2]) ? -f2_cm : f2_cm;
    end

    // ---------------------------------------------------------------
    // rotation matrix and matrix-vector product
    // ---------------------------------------------------------------
    t_back              r_c1_bk, r_c2_bk, r_c3_bk, r_c4_bk, r_c5_bk;
    logic signed [32:0] r_c1_omc, r_c2_omc;
    logic signed [31:0] r_c1_c, r_c2_c, r_c3_c;
    logic signed [63:0] r_c1_p  [9];
    logic signed [31:0] r_c2_e  [9];
    logic signed [63:0] r_c3_p  [6];
    logic signed [31:0] r_c3_ns [3];
    logic signed [33:0] r_c4_m  [9];
    logic signed [65:0] r_c5_p  [9];
    logic signed [31:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_zero;

    logic signed [31:0] c1_a [9];
    logic signed [31:0] c1_b [9];
    logic signed [33:0] c4_d [6];
    logic signed [33:0] c4_ns [3];
    logic signed [33:0] c4_c;
    logic signed [31:0] c5_v [3];
    logic signed [67:0] c6_acc [3];
    logic signed [31:0] c6_out [3];

    // operand pairs of the first product stage
    always_comb begin
        c1_a[P_XX] = r_f2_bk.nx;  c1_b[P_XX] = r_f2_bk.nx;
        c1_a[P_YY] = r_f2_bk.ny;  c1_b[P_YY] = r_f2_bk.ny;
        c1_a[P_ZZ] = r_f2_bk.nz;  c1_b[P_ZZ] = r_f2_bk.nz;
        c1_a[P_XY] = r_f2_bk.nx;  c1_b[P_XY] = r_f2_bk.ny;
        c1_a[P_XZ] = r_f2_bk.nx;  c1_b[P_XZ] = r_f2_bk.nz;
        c1_a[P_YZ] = r_f2_bk.ny;  c1_b[P_YZ] = r_f2_bk.nz;
        c1_a[P_XS] = r_f2_bk.nx;  c1_b[P_XS] = r_f2_s;
        c1_a[P_YS] = r_f2_bk.ny;  c1_b[P_YS] = r_f2_s;
        c1_a[P_ZS] = r_f2_bk.nz;  c1_b[P_ZS] = r_f2_s;
    end

    // rounded terms and matrix entries
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            c4_d[k] = 34'(rnd_q30(68'(r_c3_p[k])));
        end
        for (int k = 0; k < 3; k++) begin
            c4_ns[k] = 34'(r_c3_ns[k]);
        end
        c4_c = 34'(r_c3_c);
    end

    // row sums, rounding and clamping
    always_comb begin
        c5_v[0] = r_c5_bk.vx;
        c5_v[1] = r_c5_bk.vy;
        c5_v[2] = r_c5_bk.vz;
        for (int i = 0; i < 3; i++) begin
            c6_acc[i] = 68'(r_c5_p[3*i]) + 68'(r_c5_p[3*i+1]) + 68'(r_c5_p[3*i+2]);
            c6_out[i] = r_c5_bk.zero ? c5_v[i] : sat_q16(rnd_q30(c6_acc[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1_bk  <= r_f2_bk;
        r_c1_c   <= r_f2_c;
        r_c1_omc <= 33'sh0_4000_0000 - 33'(r_f2_c);
        for (int k = 0; k < 9; k++) begin
            r_c1_p[k] <= 64'(c1_a[k]) * 64'(c1_b[k]);
        end
        r_c2_bk  <= r_c1_bk;
        r_c2_c   <= r_c1_c;
        r_c2_omc <= r_c1_omc;
        for (int k = 0; k < 9; k++) begin
            r_c2_e[k] <= 32'(rnd_q30(68'(r_c1_p[k])));
        end
        r_c3_bk <= r_c2_bk;
        r_c3_c  <= r_c2_c;
        for (int k = 0; k < 6; k++) begin
            r_c3_p[k] <= 64'(r_c2_e[k]) * 64'(r_c2_omc);
        end
        r_c3_ns[0] <= r_c2_e[P_XS];
        r_c3_ns[1] <= r_c2_e[P_YS];
        r_c3_ns[2] <= r_c2_e[P_ZS];
        r_c4_bk   <= r_c3_bk;
        r_c4_m[0] <= c4_d[P_XX] + c4_c;
        r_c4_m[1] <= c4_d[P_XY] - c4_ns[2];
        r_c4_m[2] <= c4_d[P_XZ] + c4_ns[1];
        r_c4_m[3] <= c4_d[P_XY] + c4_ns[2];
        r_c4_m[4] <= c4_d[P_YY] + c4_c;
        r_c4_m[5] <= c4_d[P_YZ] - c4_ns[0];
        r_c4_m[6] <= c4_d[P_XZ] - c4_ns[1];
        r_c4_m[7] <= c4_d[P_YZ] + c4_ns[0];
        r_c4_m[8] <= c4_d[P_ZZ] + c4_c;
        r_c5_bk <= r_c4_bk;
        for (int i = 0; i < 3; i++) begin
            r_c5_p[3*i]   <= 66'(r_c4_bk.vx) * 66'(r_c4_m[3*i]);
            r_c5_p[3*i+1] <= 66'(r_c4_bk.vy) * 66'(r_c4_m[3*i+1]);
            r_c5_p[3*i+2] <= 66'(r_c4_bk.vz) * 66'(r_c4_m[3*i+2]);
        end
        r_out_x    <= c6_out[0];
        r_out_y    <= c6_out[1];
        r_out_z    <= c6_out[2];
        r_out_zero <= r_c5_bk.zero;
    end

    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_zero_axis = r_out_zero;

`ifndef ASSERT_OFF
    // folded angle never passes pi / 4
    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_A3] |-> (r_a3_th <= TH_MAX))
        else $error("folded angle out of range");

    // normalized axis gives a root of at least 2^30
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_D0] && !r_d0_fr.zero) |-> (r_d0_norm >= 32'h4000_0000))
        else $error("axis norm below range");

    // unit axis components stay within one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_DVL] && !r_dv_fr[DV_N-1].zero) |->
        ((r_dv_q[DV_N-1][0] <= 31'(ONE_Q30)) && (r_dv_q[DV_N-1][1] <= 31'(ONE_Q30))
         && (r_dv_q[DV_N-1][2] <= 31'(ONE_Q30))))
        else $error("unit axis component above one");

    // sine and cosine stay within one
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_F2] |->
        ((r_f2_s <= 32'sh4000_0000) && (r_f2_s >= -32'sh4000_0000)
         && (r_f2_c <= 32'sh4000_0000) && (r_f2_c >= -32'sh4000_0000)))
        else $error("sine or cosine out of range");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam longint ONE_Q30    = 64'sd1 << 30;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
    } t_rotated;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_vec_x, i_vec_y, i_vec_z, i_angle_rad;
    logic signed [31:0] i_axis_x, i_axis_y, i_axis_z;
    logic               o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic               o_zero_axis;

    t_rotated rotated_q[$];
    int       fail_count;
    int       quiet_cycles;
    bit       no_idle;

    axis_angle_vector_rotate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_angle_rad (i_angle_rad),
        .i_axis_x    (i_axis_x),
        .i_axis_y    (i_axis_y),
        .i_axis_z    (i_axis_z),
        .o_valid     (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_zero_axis (o_zero_axis)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // round to nearest, half away from zero, dropping sh bits
    function automatic longint round_shift(input longint p, input int sh);
        logic [63:0] mag;
        mag = (p < 0) ? 64'(-p) : 64'(p);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic logic [63:0] umul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // sine and cosine in q1.30 of an angle in q16.16 radians
    function automatic void sin_cos_q30(input logic signed [31:0] ang,
                                        output longint sn, output longint cs);
        logic [63:0] prod, phase, q, th, t, hs, hc, s0, c0;
        logic [2:0]  oct;
        int          sdiv[5];
        int          cdiv[5];
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{90, 56, 30, 12, 2};
        prod  = {{32{ang[31]}}, ang} * 64'h28BE60DB9391;
        phase = prod >> 32;
        oct   = phase[31:29];
        q     = {35'd0, phase[28:0]};
        if (oct[0]) q = (64'd1 << 29) - q;
        th = (q * 64'h1921FB544) >> 32;
        t  = umul_q30(th, th);
        hs = 64'(ONE_Q30);
        hc = 64'(ONE_Q30);
        for (int i = 0; i < 5; i++) begin
            hs = 64'(ONE_Q30) - umul_q30(t, hs) / 64'(sdiv[i]);
            hc = 64'(ONE_Q30) - umul_q30(t, hc) / 64'(cdiv[i]);
        end
        s0 = umul_q30(th, hs);
        c0 = hc;
        // octant folding back to the full circle
        case (oct)
            3'd0: begin sn =  longint'(s0); cs =  longint'(c0); end
            3'd1: begin sn =  longint'(c0); cs =  longint'(s0); end
            3'd2: begin sn =  longint'(c0); cs = -longint'(s0); end
            3'd3: begin sn =  longint'(s0); cs = -longint'(c0); end
            3'd4: begin sn = -longint'(s0); cs = -longint'(c0); end
            3'd5: begin sn = -longint'(c0); cs = -longint'(s0); end
            3'd6: begin sn = -longint'(c0); cs =  longint'(s0); end
            default: begin sn = -longint'(s0); cs = longint'(c0); end
        endcase
    endfunction

    function automatic logic signed [31:0] sat_q16(input longint acc);
        longint r;
        r = round_shift(acc, 30);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // rotated vector expected for one item
    function automatic t_rotated rotate_vector(input logic signed [31:0] vx, vy, vz, ang,
                                               input logic signed [31:0] ax, ay, az);
        t_rotated    res;
        longint      v[3], a[3], n[3], m[9], acc;
        longint      sn, cs, omc, xx, yy, zz, xy, xz, yz;
        logic [63:0] mag[3], mx, sum, norm, u;
        v = '{longint'(vx), longint'(vy), longint'(vz)};
        a = '{longint'(ax), longint'(ay), longint'(az)};
        if (ax == 0 && ay == 0 && az == 0) begin
            res = '{vx, vy, vz, 1'b1};
            return res;
        end
        // normalize the axis to q1.30
        for (int i = 0; i < 3; i++) mag[i] = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sum  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        norm = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            u = ((mag[i] << 30) + (norm >> 1)) / norm;
            n[i] = (a[i] < 0) ? -longint'(u) : longint'(u);
        end
        sin_cos_q30(ang, sn, cs);
        omc = ONE_Q30 - cs;
        // rotation matrix
        xx = mul_q30(mul_q30(n[0], n[0]), omc);
        yy = mul_q30(mul_q30(n[1], n[1]), omc);
        zz = mul_q30(mul_q30(n[2], n[2]), omc);
        xy = mul_q30(mul_q30(n[0], n[1]), omc);
        xz = mul_q30(mul_q30(n[0], n[2]), omc);
        yz = mul_q30(mul_q30(n[1], n[2]), omc);
        m[0] = xx + cs;
        m[1] = xy - mul_q30(n[2], sn);
        m[2] = xz + mul_q30(n[1], sn);
        m[3] = xy + mul_q30(n[2], sn);
        m[4] = yy + cs;
        m[5] = yz - mul_q30(n[0], sn);
        m[6] = xz - mul_q30(n[1], sn);
        m[7] = yz + mul_q30(n[0], sn);
        m[8] = zz + cs;
        acc = v[0] * m[0] + v[1] * m[1] + v[2] * m[2];
        res.x = sat_q16(acc);
        acc = v[0] * m[3] + v[1] * m[4] + v[2] * m[5];
        res.y = sat_q16(acc);
        acc = v[0] * m[6] + v[1] * m[7] + v[2] * m[8];
        res.z = sat_q16(acc);
        res.zero = 1'b0;
        return res;
    endfunction

    // queue the expected rotation of each accepted item, check each result
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            rotated_q.push_back(rotate_vector(i_vec_x, i_vec_y, i_vec_z, i_angle_rad,
                                              i_axis_x, i_axis_y, i_axis_z));
        end
        if (i_rst_n && o_valid) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h zero=%b", $time,
                         o_out_x, o_out_y, o_out_z, o_zero_axis);
                fail_count++;
            end else begin
                t_rotated exp_r;
                exp_r = rotated_q.pop_front();
                if (o_out_x !== exp_r.x || o_out_y !== exp_r.y || o_out_z !== exp_r.z
                        || o_zero_axis !== exp_r.zero) begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h zero=%b", $time,
                             exp_r.x, exp_r.y, exp_r.z, exp_r.zero);
                    $display("%0t:          actual   x=%h y=%h z=%h zero=%b", $time,
                             o_out_x, o_out_y, o_out_z, o_zero_axis);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item or result moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[axis_angle_vector_rotate] ERROR");
                $finish;
            end
        end
    end

    // send one item, with an occasional idle gap in front
    task automatic send_item(input logic signed [31:0] vx, vy, vz, ang, ax, ay, az);
        if (!no_idle && $urandom_range(99) < 4) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_vec_x     <= vx;
        i_vec_y     <= vy;
        i_vec_z     <= vz;
        i_angle_rad <= ang;
        i_axis_x    <= ax;
        i_axis_y    <= ay;
        i_axis_z    <= az;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // random field: full range, small q16.16 values, or an extreme
    function automatic logic signed [31:0] rand_field();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom;
        if (sel < 8) return $signed($urandom_range(20 << 16)) - (10 << 16);
        if (sel == 8) return 32'sh7FFF_FFFF;
        return 32'sh8000_0000;
    endfunction

    task automatic test_zero_axis();
        send_item(32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 0, 0, 0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0);
        send_item(-1, 1, 32'sh1234_5678, 32'sh7FFF_FFFF, 0, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0003_243F,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_921F,
                  0, 0, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh0000_C90F, 1, 0, 0);
        send_item(1, -1, 1, 32'sh7FFF_FFFF, 0, -1, 1);
        send_item(32'sh4000_0000, 32'sh4000_0000, 0, 32'sh0000_C90F, 0, 0, 32'sh0001_0000);
    endtask

    // items at each eighth of a turn over more than a full circle, plus zero and one whole turn
    task automatic test_octants();
        logic signed [31:0] ang;
        for (int k = -2; k < 10; k++) begin
            ang = 32'(k * 32'sd51472 + 32'sd1000);
            send_item(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, ang,
                      32'sh0000_8000, -32'sh0001_0000, 32'sh0002_0000);
        end
        send_item(32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0);
        send_item(32'sh0005_0000, 0, 0, 32'sh0006_487F, 0, 32'sh0001_0000, 0);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] ax, ay, az;
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= count / 3 && i < count / 2);
            ax = rand_field();
            ay = rand_field();
            az = rand_field();
            // axis along one coordinate, or all zero, now and then
            case ($urandom_range(15))
                0: begin ax = 0; ay = 0; az = 0; end
                1: begin ay = 0; az = 0; end
                2: begin ax = 0; az = 0; end
                3: begin ax = 0; ay = 0; end
                default: ;
            endcase
            send_item(rand_field(), rand_field(), rand_field(), rand_field(), ax, ay, az);
        end
        no_idle = 0;
    endtask

    initial begin
        fail_count  = 0;
        no_idle     = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_vec_x     = 0;
        i_vec_y     = 0;
        i_vec_z     = 0;
        i_angle_rad = 0;
        i_axis_x    = 0;
        i_axis_y    = 0;
        i_axis_z    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_axis();
        test_field_extremes();
        test_octants();
        test_random(1700);

        // drain the pipeline
        start <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[axis_angle_vector_rotate] OK");
        end else begin
            $display("[axis_angle_vector_rotate] ERROR");
        end
        $finish;
    end

endmodule
